// File: rtl/texture_mip_layout_calculator_defines.svh
// Assertion macros used by the layout calculator back end.
`ifndef TEXTURE_MIP_LAYOUT_CALCULATOR_DEFINES_SVH
`define TEXTURE_MIP_LAYOUT_CALCULATOR_DEFINES_SVH

// Implication checked at every clock edge outside reset.
`define TMLC_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Non-overlapping implication checked outside reset.
`define TMLC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/tmlc_pkg.sv
// ---------------------------------------------------------------------------
// tmlc_pkg
// Types, constants and tables for the texture mip layout calculator.
// ---------------------------------------------------------------------------
package tmlc_pkg;

    localparam int MAX_LEVELS = 15;
    localparam int MAX_EXTENT = 16384;

    localparam logic [1:0] KIND_2D   = 2'd0;
    localparam logic [1:0] KIND_3D   = 2'd1;
    localparam logic [1:0] KIND_CUBE = 2'd2;
    localparam logic [1:0] KIND_BAD  = 2'd3;

    localparam logic [2:0] DATA_PACKED = 3'd5;

    localparam logic [2:0] REG_WIDTH  = 3'd0;
    localparam logic [2:0] REG_HEIGHT = 3'd1;
    localparam logic [2:0] REG_DEPTH  = 3'd2;
    localparam logic [2:0] REG_LEVELS = 3'd3;
    localparam logic [2:0] REG_KIND   = 3'd4;
    localparam logic [2:0] REG_LAYOUT = 3'd5;

    typedef struct packed {
        logic [3:0]  mip_level;
        logic [2:0]  cube_face;
        logic [10:0] slice_index;
    } req_t;

    typedef struct packed {
        logic [1:0]  texture_kind;
        logic [14:0] level_width;
        logic [14:0] level_height;
        logic [11:0] level_depth;
        logic [4:0]  pixel_bytes;
        logic [18:0] line_bytes;
        logic [31:0] level_bytes;
        logic [31:0] image_bytes;
        logic [31:0] level_offset;
        logic [31:0] face_offset;
        logic [31:0] slice_offset;
    } res_t;

    // Classified request handed from the front to the back.
    typedef struct packed {
        logic [3:0]  mip_level;
        logic [2:0]  cube_face;
        logic [10:0] slice_index;
        logic [1:0]  kind;
        logic [4:0]  bpp;
        logic [4:0]  bpb;
        logic        packed_fmt;
        logic [14:0] eff_w;
        logic [14:0] eff_h;
        logic [11:0] depth;
        logic [3:0]  lim;
    } job_t;

    // Bytes per pixel, or per 4x4 block for compressed data.
    function automatic logic [4:0] unit_bytes(input logic [2:0] kind, input logic [2:0] lay);
        logic [4:0] base;
        logic [4:0] r;
        begin
            case (lay)
                3'd0, 3'd2: base = 5'd1;
                3'd1, 3'd3: base = 5'd2;
                3'd4, 3'd6: base = 5'd3;
                default:    base = 5'd4;
            endcase
            case (kind)
                3'd0:       r = base;
                3'd1, 3'd3: r = 5'(base << 1);
                3'd2, 3'd4: r = 5'(base << 2);
                3'd5:
                begin
                    case (lay)
                        3'd0, 3'd2, 3'd4: r = 5'd8;
                        3'd1, 3'd3, 3'd5: r = 5'd16;
                        default:          r = 5'd0;
                    endcase
                end
                default:    r = 5'd0;
            endcase
            unit_bytes = r;
        end
    endfunction

endpackage

// File: rtl/tmlc_front.sv
// ---------------------------------------------------------------------------
// tmlc_front
// Holds configuration, classifies each request and queues it as a job.
// ---------------------------------------------------------------------------
module tmlc_front
    import tmlc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        push,
    output logic        full,
    input  req_t        req,
    output logic        job_valid,
    input  logic        job_take,
    output job_t        job
);

    logic [14:0] width_reg, height_reg;
    logic [11:0] depth_reg;
    logic [3:0]  levels_reg;
    logic [2:0]  kind_reg, layout_reg;

    // Two-entry job queue.
    job_t       q_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    job_t        cls;
    logic [14:0] ew, eh;
    logic        bad;

    assign cfg_ready = 1'b1;
    assign full      = (cnt_reg == 2'd2);
    assign job_valid = (cnt_reg != 2'd0);
    assign job       = q_reg[rp_reg];

    // Classify the request against current configuration.
    always_comb
    begin
        ew  = (width_reg > 15'(MAX_EXTENT)) ? 15'(MAX_EXTENT) : width_reg;
        eh  = (height_reg > 15'(MAX_EXTENT)) ? 15'(MAX_EXTENT) : height_reg;
        bad = (kind_reg > DATA_PACKED) ||
              (kind_reg == DATA_PACKED && layout_reg >= 3'd6);
        cls.mip_level   = req.mip_level;
        cls.cube_face   = req.cube_face;
        cls.slice_index = req.slice_index;
        cls.packed_fmt  = (kind_reg == DATA_PACKED);
        cls.bpp = (kind_reg < DATA_PACKED) ? unit_bytes(kind_reg, layout_reg) : 5'd0;
        cls.bpb = cls.packed_fmt ? unit_bytes(kind_reg, layout_reg) : 5'd0;
        cls.eff_w = ew;
        cls.eff_h = eh;
        cls.depth = depth_reg;
        cls.lim   = (levels_reg > 4'(MAX_LEVELS)) ? 4'(MAX_LEVELS) : levels_reg;
        if (bad)
            cls.kind = KIND_BAD;
        else if (depth_reg == 12'd0 && ew == eh)
            cls.kind = KIND_CUBE;
        else if (depth_reg > 12'd1)
            cls.kind = KIND_3D;
        else if (depth_reg == 12'd1)
            cls.kind = KIND_2D;
        else
            cls.kind = KIND_BAD;
    end

    // Store configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 15'd1;
            height_reg <= 15'd1;
            depth_reg  <= 12'd1;
            levels_reg <= 4'd1;
            kind_reg   <= 3'd0;
            layout_reg <= 3'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_WIDTH:  width_reg  <= cfg_data[14:0];
                REG_HEIGHT: height_reg <= cfg_data[14:0];
                REG_DEPTH:  depth_reg  <= cfg_data[11:0];
                REG_LEVELS: levels_reg <= cfg_data[3:0];
                REG_KIND:   kind_reg   <= cfg_data[2:0];
                REG_LAYOUT: layout_reg <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // Advance queue pointers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push && !full)
                wp_reg <= ~wp_reg;
            if (job_take && job_valid)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(push && !full) - 2'(job_take && job_valid);
        end
    end

    // Write the queue entry.
    always_ff @(posedge clk)
    begin
        if (push && !full)
            q_reg[wp_reg] <= cls;
    end

endmodule

// File: rtl/tmlc_back.sv
// ---------------------------------------------------------------------------
// tmlc_back
// Walks the levels with one shared multiplier and builds the result beat.
// ---------------------------------------------------------------------------
module tmlc_back
    import tmlc_pkg::*;
`include "texture_mip_layout_calculator_defines.svh"
(
    input  logic clk,
    input  logic rst_n,
    input  logic job_valid,
    output logic job_take,
    input  job_t job,
    output logic empty,
    input  logic pop,
    output res_t res
);

    typedef enum logic [2:0] {
        S_IDLE, S_LVL, S_M1, S_M2, S_M3, S_F1, S_F2, S_DONE
    } state_t;

    state_t      state_reg;
    job_t        job_reg;
    logic [3:0]  lvl_reg;
    logic [1:0]  step_reg;
    logic [31:0] acc_reg, img_reg, off_reg, lb_reg, prod_reg, tmp_reg;
    logic [31:0] quo_reg;
    res_t        res_reg;
    logic        full_reg;

    logic [31:0] ma, mb, mp;
    logic [14:0] lw, lh, sw, sh;
    logic [11:0] ld, sd;
    logic [31:0] dterm;
    logic [3:0]  upto;

    assign job_take = (state_reg == S_IDLE) && job_valid && !full_reg;
    assign empty    = !full_reg;
    assign res      = res_reg;

    // Extents at the level being walked.
    always_comb
    begin
        sw = job_reg.eff_w >> lvl_reg;
        sh = job_reg.eff_h >> lvl_reg;
        sd = job_reg.depth >> lvl_reg;
        lw = (sw == 15'd0) ? 15'd1 : sw;
        lh = (sh == 15'd0) ? 15'd1 : sh;
        ld = (sd == 12'd0) ? 12'd1 : sd;
        dterm = (job_reg.kind == KIND_CUBE) ? 32'd6 : 32'(ld);
        // Levels below this one make up the level offset.
        upto = (job_reg.mip_level < job_reg.lim) ? job_reg.mip_level : job_reg.lim;
    end

    // Shared multiplier operand select.
    always_comb
    begin
        ma = prod_reg;
        mb = 32'd0;
        case (state_reg)
            S_LVL:
            begin
                ma = job_reg.packed_fmt ? 32'((lw + 15'd3) >> 2) : 32'(lw);
                mb = job_reg.packed_fmt ? 32'((lh + 15'd3) >> 2) : 32'(lh);
            end
            S_M1: mb = dterm;
            S_M2: mb = job_reg.packed_fmt ? 32'(job_reg.bpb) : 32'(job_reg.bpp);
            S_F1:
            begin
                ma = 32'(job_reg.cube_face);
                mb = img_reg;
            end
            S_F2:
            begin
                ma = (step_reg == 2'd0) ? 32'(lw) : prod_reg;
                mb = (step_reg == 2'd0) ? 32'(lh) :
                     (step_reg == 2'd1) ? 32'(job_reg.slice_index) : 32'(job_reg.bpp);
            end
            default: ;
        endcase
        mp = ma * mb;
    end

    // Sequencer: level sizes, sums, then face and slice offsets.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            full_reg  <= 1'b0;
        end
        else
        begin
            // Load a finished beat, or drop the popped one.
            if (state_reg == S_DONE && (!full_reg || pop))
                full_reg <= 1'b1;
            else if (pop && full_reg)
                full_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (job_take)
                    begin
                        job_reg   <= job;
                        lvl_reg   <= 4'd0;
                        acc_reg   <= 32'd0;
                        off_reg   <= 32'd0;
                        state_reg <= S_LVL;
                    end
                end
                S_LVL:
                begin
                    prod_reg  <= mp;
                    state_reg <= S_M1;
                end
                S_M1:
                begin
                    prod_reg  <= mp;
                    state_reg <= S_M2;
                end
                S_M2:
                begin
                    // mp is the size of level lvl_reg
                    if (lvl_reg == job_reg.mip_level)
                        lb_reg <= mp;
                    if (lvl_reg == upto)
                        off_reg <= acc_reg;
                    if (lvl_reg < job_reg.lim)
                        acc_reg <= acc_reg + mp;
                    if (lvl_reg == 4'd15)
                        state_reg <= S_M3;
                    else
                    begin
                        lvl_reg   <= lvl_reg + 4'd1;
                        state_reg <= S_LVL;
                    end
                end
                S_M3:
                begin
                    img_reg   <= acc_reg;
                    lvl_reg   <= job_reg.mip_level;
                    state_reg <= S_F1;
                end
                S_F1:
                begin
                    // Face numerator; divide by six follows by reciprocal multiply.
                    tmp_reg   <= mp + off_reg;
                    step_reg  <= 2'd0;
                    state_reg <= S_F2;
                end
                S_F2:
                begin
                    // Estimate the quotient, may be one too high.
                    if (step_reg == 2'd0)
                        quo_reg <= 32'((64'(tmp_reg) * 64'h2AAAAAAB) >> 32);
                    prod_reg <= mp;
                    if (step_reg == 2'd2)
                        state_reg <= S_DONE;
                    step_reg <= step_reg + 2'd1;
                end
                S_DONE:
                begin
                    if (!full_reg || pop)
                    begin
                        res_reg.texture_kind <= job_reg.kind;
                        res_reg.level_width  <= lw;
                        res_reg.level_height <= lh;
                        res_reg.level_depth  <= ld;
                        res_reg.pixel_bytes  <= job_reg.bpp;
                        res_reg.line_bytes   <= 19'(32'(lw) * 32'(job_reg.bpp));
                        res_reg.level_bytes  <= lb_reg;
                        res_reg.image_bytes  <= img_reg;
                        res_reg.level_offset <= (job_reg.kind == KIND_CUBE) ? 32'd0 : off_reg;
                        res_reg.face_offset  <= (job_reg.kind == KIND_CUBE)
                                                ? quo_reg - ((quo_reg * 32'd6 > tmp_reg)
                                                             ? 32'd1 : 32'd0)
                                                : 32'd0;
                        res_reg.slice_offset <= (job_reg.kind == KIND_3D)
                                                ? off_reg + prod_reg : 32'd0;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `TMLC_ASSERT_IMPL(a_take_idle, job_take, state_reg == S_IDLE)
    `TMLC_ASSERT_NEXT(a_take_walk, job_take, state_reg == S_LVL)
    `TMLC_ASSERT_IMPL(a_lim_ok, state_reg != S_IDLE, job_reg.lim <= 4'(MAX_LEVELS))

endmodule

// File: rtl/texture_mip_layout_calculator.sv
// ---------------------------------------------------------------------------
// texture_mip_layout_calculator
// Mip level sizes and byte offsets for one configured texture.
// ---------------------------------------------------------------------------
// Usage: write the texture description through the cfg channel (index 0..5:
// width, height, depth, level count, data kind, channel layout) while idle.
// Push a request (mip level, cube face, slice) when full is low; one result
// beat appears on result ports while empty is low and leaves on pop.
// The back end takes the job, walks all sixteen levels through the states
// S_LVL, S_M1 and S_M2 on one shared multiplier, then forms the face and
// slice offsets in S_M3, S_F1 and S_F2 and loads the result in S_DONE. One
// request is worked at a time, and the next starts only after the finished
// beat is popped; a two-entry queue in front accepts requests meanwhile.
// Reset loads width, height, depth and level count 1, kind and layout 0, and
// empties the queue and result register. When pop stays low the finished
// beat holds and the back end waits; the front queue then fills and raises full.
// ---------------------------------------------------------------------------
module texture_mip_layout_calculator
    import tmlc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        push,
    output logic        full,
    input  req_t        req,
    output logic        empty,
    input  logic        pop,
    output res_t        res
);

    logic job_valid, job_take;
    job_t job;

    tmlc_front u_front (
        .clk, .rst_n, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
        .push, .full, .req, .job_valid, .job_take, .job
    );

    tmlc_back u_back (
        .clk, .rst_n, .job_valid, .job_take, .job, .empty, .pop, .res
    );

endmodule
